>>> src/lad_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the latency anomaly detector
package lad_pkg;

  localparam int REQ_W      = 2;
  localparam int CH_W       = 4;
  localparam int THR_W      = 26;
  localparam int SEV_W      = 2;
  localparam int K_W        = 12;
  localparam int MIN_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_CHECK   = 2'd1,
    REQ_CLR_CH  = 2'd2,
    REQ_CLR_ALL = 2'd3
  } lad_req_t;

  localparam logic [SEV_W-1:0] SEV_NORMAL = 2'd0;
  localparam logic [SEV_W-1:0] SEV_WARN   = 2'd1;
  localparam logic [SEV_W-1:0] SEV_CRIT   = 2'd2;

  localparam logic [1:0] DET_NONE   = 2'd0;
  localparam logic [1:0] DET_THRESH = 2'd1;
  localparam logic [1:0] DET_STAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WARN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_FIX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_STA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_K      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 3'd5;

  localparam logic [THR_W-1:0] RST_WARN = 26'd10000000;
  localparam logic [THR_W-1:0] RST_CRIT = 26'd50000000;
  localparam logic [K_W-1:0]   RST_K    = 12'd768;
  localparam logic [MIN_W-1:0] RST_MIN  = 10'd100;
  localparam logic [THR_W-1:0] THR_MAX  = '1;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_OLD   = 12'b0000_0000_0010,
    ST_SQX   = 12'b0000_0000_0100,
    ST_UPD   = 12'b0000_0000_1000,
    ST_SETUP = 12'b0000_0001_0000,
    ST_NQ    = 12'b0000_0010_0000,
    ST_SS    = 12'b0000_0100_0000,
    ST_SQRT  = 12'b0000_1000_0000,
    ST_KR    = 12'b0001_0000_0000,
    ST_CMP   = 12'b0010_0000_0000,
    ST_DIV   = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } lad_state_t;

endpackage

>>> src/lad_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module lad_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 16000
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/latency_anomaly_detector.sv
`timescale 1ns / 1ps
// Per-channel latency monitor: each channel keeps a window of its last WINDOW samples in one
// shared sample ram, with running sum and sum of squares, and flags samples at or above fixed
// warning/critical levels or above mean + k*stddev. One request is handled at a time and
// in_ready is high only while idle. A clear, a rejected request or an ignored channel goes
// from idle straight to the done state; a sample settled by the fixed levels passes through
// the old-value read, square and update states first. When the statistical test runs, one
// add/subtract unit does all the arithmetic a bit per cycle: n*Q (counter bits), S*S (sum
// bits), integer square root (as many steps as sum bits), k*root (12 bits) and a compare; a
// window check that alerts also divides by the fill count one quotient bit per cycle. A
// finished result sits in the output register while the next request is taken.
module latency_anomaly_detector #(
  parameter int WINDOW       = 1000,
  parameter int NUM_CHANNELS = 16,
  parameter int LATENCY_BITS = 26
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lad_pkg::REQ_W-1:0]        in_req_type,
  input  logic [lad_pkg::CH_W-1:0]         in_channel,
  input  logic [lad_pkg::THR_W-1:0]        in_latency,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lad_pkg::SEV_W-1:0]        out_severity,
  output logic [lad_pkg::SEV_W-1:0]        out_channel_status,
  output logic                             out_alert,
  output logic [1:0]                       out_detect_method,
  output logic [lad_pkg::THR_W-1:0]        out_alert_threshold,
  output logic [lad_pkg::THR_W-1:0]        out_alert_latency,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lad_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int L       = LATENCY_BITS;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int POS_W   = $clog2(WINDOW);
  localparam int SUM_W   = L + CNT_W;
  localparam int SQ_W    = 2 * L + CNT_W;
  localparam int D_W     = SQ_W + CNT_W;
  localparam int R_W     = (D_W + 1) / 2;
  localparam int RAD_W   = 2 * R_W;
  localparam int ALU_W   = RAD_W + 1;
  localparam int MC_W    = D_W;
  localparam int MPL_W   = SUM_W;
  localparam int XN_W    = L + CNT_W;
  localparam int NUM_W   = ((SUM_W + 8 > lad_pkg::K_W + R_W) ? SUM_W + 8
                           : lad_pkg::K_W + R_W) + 1;
  localparam int DIVD_W  = NUM_W - 8;
  localparam int QE_W    = (DIVD_W > lad_pkg::THR_W) ? DIVD_W : lad_pkg::THR_W;
  localparam int STEP_W  = $clog2(RAD_W + 1);
  localparam int MCMP_W  = (CNT_W > lad_pkg::MIN_W) ? CNT_W : lad_pkg::MIN_W;
  localparam int DEPTH   = NUM_CHANNELS * WINDOW;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W   = ($clog2(NUM_CHANNELS) < 1) ? 1
                         : (($clog2(NUM_CHANNELS) > lad_pkg::CH_W) ? lad_pkg::CH_W
                         : $clog2(NUM_CHANNELS));
  localparam logic [L-1:0]      LAT_MAX = '1;
  localparam logic [ADDR_W-1:0] WIN_A   = ADDR_W'(WINDOW);
  localparam logic [POS_W-1:0]  POS_TOP = POS_W'(WINDOW - 1);

  // configuration
  logic [lad_pkg::THR_W-1:0] warn_r, crit_r;
  logic                      en_fix_r, en_sta_r;
  logic [lad_pkg::K_W-1:0]   k_r;
  logic [lad_pkg::MIN_W-1:0] min_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r   <= lad_pkg::RST_WARN;
      crit_r   <= lad_pkg::RST_CRIT;
      en_fix_r <= 1'b1;
      en_sta_r <= 1'b1;
      k_r      <= lad_pkg::RST_K;
      min_r    <= lad_pkg::RST_MIN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lad_pkg::CFG_WARN:   warn_r   <= cfg_data;
        lad_pkg::CFG_CRIT:   crit_r   <= cfg_data;
        lad_pkg::CFG_EN_FIX: en_fix_r <= cfg_data[0];
        lad_pkg::CFG_EN_STA: en_sta_r <= cfg_data[0];
        lad_pkg::CFG_K:      k_r      <= cfg_data[lad_pkg::K_W-1:0];
        lad_pkg::CFG_MIN:    min_r    <= cfg_data[lad_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // per-channel state
  logic [POS_W-1:0]  pos_arr_r  [NUM_CHANNELS];
  logic [CNT_W-1:0]  fill_arr_r [NUM_CHANNELS];
  logic [SUM_W-1:0]  sum_arr_r  [NUM_CHANNELS];
  logic [SQ_W-1:0]   sq_arr_r   [NUM_CHANNELS];
  logic [lad_pkg::SEV_W-1:0] stat_arr_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]   seen_r;

  // sequencer and datapath registers
  lad_pkg::lad_state_t state_r, state_nxt;
  lad_pkg::lad_req_t   req_r, req_nxt;
  logic [IDX_W-1:0]    ch_r, ch_nxt;
  logic [L-1:0]        x_r, x_nxt, tv_r, tv_nxt, old_r, old_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [2*L-1:0]      sq_old_r, sq_old_nxt, sq_x_r, sq_x_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [XN_W-1:0]     xn_r, xn_nxt;
  logic [ALU_W-1:0]    acc_r, acc_nxt;
  logic [MC_W-1:0]     mcand_r, mcand_nxt;
  logic [MPL_W-1:0]    mplier_r, mplier_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [R_W:0]        rem_r, rem_nxt;
  logic [R_W-1:0]      root_r, root_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;

  logic [lad_pkg::SEV_W-1:0] res_sev_r, res_sev_nxt, res_stat_r, res_stat_nxt;
  logic [1:0]                res_meth_r, res_meth_nxt;
  logic [lad_pkg::THR_W-1:0] res_thr_r, res_thr_nxt, res_lat_r, res_lat_nxt;

  logic                      out_valid_r;
  logic [lad_pkg::SEV_W-1:0] out_sev_r, out_stat_r;
  logic [1:0]                out_meth_r;
  logic [lad_pkg::THR_W-1:0] out_thr_r, out_lat_r;

  // control towards channel state and ram
  logic                      clr_all, clr_one, upd_we, st_we, out_load, ram_we;
  logic [lad_pkg::SEV_W-1:0] st_val;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [L-1:0]              ram_rdata;

  // input side decode
  lad_pkg::lad_req_t req_in;
  logic [IDX_W-1:0]  ch_in;
  logic              in_rng;
  logic [L-1:0]      x_sat;
  logic [POS_W-1:0]  pos_in, pos_use;

  assign req_in = lad_pkg::lad_req_t'(in_req_type);
  assign ch_in  = in_channel[IDX_W-1:0];
  assign in_rng = (32'(in_channel) < NUM_CHANNELS);
  assign x_sat  = (in_latency > lad_pkg::THR_W'(LAT_MAX)) ? LAT_MAX : in_latency[L-1:0];
  assign pos_in = pos_arr_r[ch_in];
  // newest entry sits just behind the write position
  assign pos_use = (req_in == lad_pkg::REQ_SAMPLE) ? pos_in
                 : ((pos_in == '0) ? POS_TOP : pos_in - POS_W'(1));
  assign ram_raddr = ADDR_W'(ch_in) * WIN_A + ADDR_W'(pos_use);

  lad_ram #(.WIDTH(L), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (x_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier, one use per state
  logic [L-1:0]   mul_a, mul_b;
  logic [2*L-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // shared add/subtract unit
  logic [ALU_W-1:0] alu_a, alu_b;
  logic             alu_sub, alu_carry;
  logic [ALU_W:0]   alu_sum;
  logic [R_W+2:0]   sq_a;
  logic [CNT_W:0]   dv_a;

  assign sq_a = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign dv_a = {rem_r[CNT_W-1:0], rad_r[DIVD_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      lad_pkg::ST_NQ, lad_pkg::ST_KR: begin
        alu_a = acc_r;
        alu_b = mplier_r[0] ? ALU_W'(mcand_r) : '0;
      end
      lad_pkg::ST_SS: begin
        alu_a   = acc_r;
        alu_b   = mplier_r[0] ? ALU_W'(mcand_r) : '0;
        alu_sub = 1'b1;
      end
      lad_pkg::ST_SQRT: begin
        alu_a   = ALU_W'(sq_a);
        alu_b   = ALU_W'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      lad_pkg::ST_CMP: begin
        alu_a   = acc_r;
        alu_b   = ALU_W'({xn_r, 8'b0});
        alu_sub = 1'b1;
      end
      lad_pkg::ST_DIV: begin
        alu_a   = ALU_W'(dv_a);
        alu_b   = ALU_W'(n_r);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (ALU_W + 1)'(alu_sub);
  assign alu_carry = alu_sum[ALU_W];

  // per-channel view at the latched channel, and the fill count at the input channel
  logic [CNT_W-1:0] fill_ch, fill_in, fill_new;
  logic             full_ch, seen_ch, last_step, fix_crit, fix_warn, d_pos;
  logic [QE_W-1:0]  quo_e;

  assign fill_ch   = fill_arr_r[ch_r];
  assign fill_in   = fill_arr_r[ch_in];
  assign full_ch   = (fill_ch >= CNT_W'(WINDOW));
  assign fill_new  = full_ch ? fill_ch : fill_ch + CNT_W'(1);
  assign seen_ch   = seen_r[ch_r];
  assign last_step = (cnt_r == STEP_W'(1));
  assign fix_crit  = en_fix_r && (lad_pkg::THR_W'(x_r) >= crit_r);
  assign fix_warn  = en_fix_r && (lad_pkg::THR_W'(x_r) >= warn_r);
  assign d_pos     = !alu_sum[ALU_W-1] && (alu_sum[ALU_W-1:0] != '0);
  assign quo_e     = QE_W'(rad_nxt[DIVD_W-1:0]);

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    ch_nxt       = ch_r;
    x_nxt        = x_r;
    tv_nxt       = tv_r;
    old_nxt      = old_r;
    addr_nxt     = addr_r;
    sq_old_nxt   = sq_old_r;
    sq_x_nxt     = sq_x_r;
    n_nxt        = n_r;
    xn_nxt       = xn_r;
    acc_nxt      = acc_r;
    mcand_nxt    = mcand_r;
    mplier_nxt   = mplier_r;
    rad_nxt      = rad_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    cnt_nxt      = cnt_r;
    res_sev_nxt  = res_sev_r;
    res_stat_nxt = res_stat_r;
    res_meth_nxt = res_meth_r;
    res_thr_nxt  = res_thr_r;
    res_lat_nxt  = res_lat_r;
    clr_all      = 1'b0;
    clr_one      = 1'b0;
    upd_we       = 1'b0;
    st_we        = 1'b0;
    st_val       = lad_pkg::SEV_NORMAL;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    mul_a        = x_r;
    mul_b        = x_r;

    unique case (state_r)
      lad_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt      = req_in;
          ch_nxt       = ch_in;
          x_nxt        = x_sat;
          tv_nxt       = x_sat;
          addr_nxt     = ram_raddr;
          res_sev_nxt  = lad_pkg::SEV_NORMAL;
          res_meth_nxt = lad_pkg::DET_NONE;
          res_thr_nxt  = '0;
          res_lat_nxt  = '0;
          res_stat_nxt = in_rng ? stat_arr_r[ch_in] : lad_pkg::SEV_NORMAL;
          state_nxt    = lad_pkg::ST_DONE;
          if (req_in == lad_pkg::REQ_CLR_ALL) begin
            clr_all      = 1'b1;
            res_stat_nxt = lad_pkg::SEV_NORMAL;
          end else if (in_rng) begin
            unique case (req_in)
              lad_pkg::REQ_CLR_CH: begin
                clr_one      = 1'b1;
                res_stat_nxt = lad_pkg::SEV_NORMAL;
              end
              lad_pkg::REQ_SAMPLE: state_nxt = lad_pkg::ST_OLD;
              lad_pkg::REQ_CHECK: begin
                if (seen_r[ch_in] && (fill_in != '0) &&
                    (MCMP_W'(fill_in) >= MCMP_W'(min_r))) begin
                  state_nxt = lad_pkg::ST_OLD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      lad_pkg::ST_OLD: begin
        mul_a      = ram_rdata;
        mul_b      = ram_rdata;
        old_nxt    = ram_rdata;
        sq_old_nxt = mul_p;
        if (req_r == lad_pkg::REQ_SAMPLE) begin
          ram_we    = 1'b1;
          state_nxt = lad_pkg::ST_SQX;
        end else begin
          tv_nxt    = ram_rdata;
          state_nxt = lad_pkg::ST_SETUP;
        end
      end
      lad_pkg::ST_SQX: begin
        sq_x_nxt  = mul_p;
        state_nxt = lad_pkg::ST_UPD;
      end
      lad_pkg::ST_UPD: begin
        upd_we    = 1'b1;
        state_nxt = lad_pkg::ST_DONE;
        if (seen_ch) begin
          st_we = 1'b1;
          if (fix_crit || fix_warn) begin
            st_val       = fix_crit ? lad_pkg::SEV_CRIT : lad_pkg::SEV_WARN;
            res_sev_nxt  = st_val;
            res_stat_nxt = st_val;
            res_meth_nxt = lad_pkg::DET_THRESH;
            res_thr_nxt  = fix_crit ? crit_r : warn_r;
            res_lat_nxt  = lad_pkg::THR_W'(x_r);
          end else if (en_sta_r && (MCMP_W'(fill_new) >= MCMP_W'(min_r))) begin
            st_we     = 1'b0;
            state_nxt = lad_pkg::ST_SETUP;
          end else begin
            res_stat_nxt = lad_pkg::SEV_NORMAL;
          end
        end
      end
      lad_pkg::ST_SETUP: begin
        mul_a      = tv_r;
        mul_b      = L'(fill_ch);
        xn_nxt     = mul_p[XN_W-1:0];
        n_nxt      = fill_ch;
        acc_nxt    = '0;
        mcand_nxt  = MC_W'(sq_arr_r[ch_r]);
        mplier_nxt = MPL_W'(fill_ch);
        cnt_nxt    = STEP_W'(CNT_W);
        state_nxt  = lad_pkg::ST_NQ;
      end
      lad_pkg::ST_NQ: begin
        acc_nxt    = alu_sum[ALU_W-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - STEP_W'(1);
        if (last_step) begin
          mcand_nxt  = MC_W'(sum_arr_r[ch_r]);
          mplier_nxt = sum_arr_r[ch_r];
          cnt_nxt    = STEP_W'(SUM_W);
          state_nxt  = lad_pkg::ST_SS;
        end
      end
      lad_pkg::ST_SS: begin
        acc_nxt    = alu_sum[ALU_W-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - STEP_W'(1);
        if (last_step) begin
          if (d_pos) begin
            rad_nxt   = RAD_W'(alu_sum[D_W-1:0]);
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = STEP_W'(R_W);
            state_nxt = lad_pkg::ST_SQRT;
          end else begin
            // zero spread: no statistical verdict
            state_nxt = lad_pkg::ST_DONE;
            if (req_r == lad_pkg::REQ_SAMPLE) begin
              st_we        = 1'b1;
              res_stat_nxt = lad_pkg::SEV_NORMAL;
            end
          end
        end
      end
      lad_pkg::ST_SQRT: begin
        rad_nxt = rad_r << 2;
        cnt_nxt = cnt_r - STEP_W'(1);
        if (alu_carry) begin
          rem_nxt  = alu_sum[R_W:0];
          root_nxt = {root_r[R_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_a[R_W:0];
          root_nxt = {root_r[R_W-2:0], 1'b0};
        end
        if (last_step) begin
          acc_nxt    = ALU_W'({sum_arr_r[ch_r], 8'b0});
          mcand_nxt  = MC_W'(root_nxt);
          mplier_nxt = MPL_W'(k_r);
          cnt_nxt    = STEP_W'(lad_pkg::K_W);
          state_nxt  = lad_pkg::ST_KR;
        end
      end
      lad_pkg::ST_KR: begin
        acc_nxt    = alu_sum[ALU_W-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - STEP_W'(1);
        if (last_step) begin
          state_nxt = lad_pkg::ST_CMP;
        end
      end
      lad_pkg::ST_CMP: begin
        state_nxt = lad_pkg::ST_DONE;
        // borrow means x*256*n is above the numerator
        if (!alu_carry) begin
          res_lat_nxt = lad_pkg::THR_W'(tv_r);
          if (req_r == lad_pkg::REQ_SAMPLE) begin
            st_we        = 1'b1;
            st_val       = lad_pkg::SEV_WARN;
            res_sev_nxt  = lad_pkg::SEV_WARN;
            res_stat_nxt = lad_pkg::SEV_WARN;
            res_meth_nxt = lad_pkg::DET_THRESH;
            res_thr_nxt  = warn_r;
          end else begin
            res_sev_nxt  = (lad_pkg::THR_W'(tv_r) >= crit_r) ? lad_pkg::SEV_CRIT
                                                             : lad_pkg::SEV_WARN;
            res_meth_nxt = lad_pkg::DET_STAT;
            rad_nxt      = RAD_W'(acc_r[NUM_W-1:8]);
            rem_nxt      = '0;
            cnt_nxt      = STEP_W'(DIVD_W);
            state_nxt    = lad_pkg::ST_DIV;
          end
        end else if (req_r == lad_pkg::REQ_SAMPLE) begin
          st_we        = 1'b1;
          res_stat_nxt = lad_pkg::SEV_NORMAL;
        end
      end
      lad_pkg::ST_DIV: begin
        rad_nxt = {rad_r[RAD_W-2:0], alu_carry};
        rem_nxt = alu_carry ? (R_W + 1)'(alu_sum[CNT_W:0]) : (R_W + 1)'(dv_a);
        cnt_nxt = cnt_r - STEP_W'(1);
        if (last_step) begin
          res_thr_nxt = (quo_e > QE_W'(lad_pkg::THR_MAX)) ? lad_pkg::THR_MAX
                                                          : quo_e[lad_pkg::THR_W-1:0];
          state_nxt   = lad_pkg::ST_DONE;
        end
      end
      lad_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = lad_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lad_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ch_r       <= ch_nxt;
    x_r        <= x_nxt;
    tv_r       <= tv_nxt;
    old_r      <= old_nxt;
    addr_r     <= addr_nxt;
    sq_old_r   <= sq_old_nxt;
    sq_x_r     <= sq_x_nxt;
    n_r        <= n_nxt;
    xn_r       <= xn_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    cnt_r      <= cnt_nxt;
    res_sev_r  <= res_sev_nxt;
    res_stat_r <= res_stat_nxt;
    res_meth_r <= res_meth_nxt;
    res_thr_r  <= res_thr_nxt;
    res_lat_r  <= res_lat_nxt;
    if (out_load) begin
      out_sev_r  <= res_sev_r;
      out_stat_r <= res_stat_r;
      out_meth_r <= res_meth_r;
      out_thr_r  <= res_thr_r;
      out_lat_r  <= res_lat_r;
    end
  end

  // channel state: clears, window update, stored severity
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pos_arr_r[c]  <= '0;
        fill_arr_r[c] <= '0;
        sum_arr_r[c]  <= '0;
        sq_arr_r[c]   <= '0;
        stat_arr_r[c] <= lad_pkg::SEV_NORMAL;
      end
      seen_r <= '0;
    end else begin
      if (clr_one) begin
        pos_arr_r[ch_in]  <= '0;
        fill_arr_r[ch_in] <= '0;
        sum_arr_r[ch_in]  <= '0;
        sq_arr_r[ch_in]   <= '0;
        stat_arr_r[ch_in] <= lad_pkg::SEV_NORMAL;
        seen_r[ch_in]     <= 1'b0;
      end
      if (upd_we) begin
        pos_arr_r[ch_r]  <= (pos_arr_r[ch_r] == POS_TOP) ? '0
                          : pos_arr_r[ch_r] + POS_W'(1);
        fill_arr_r[ch_r] <= fill_new;
        sum_arr_r[ch_r]  <= sum_arr_r[ch_r] + SUM_W'(x_r)
                          - (full_ch ? SUM_W'(old_r) : '0);
        sq_arr_r[ch_r]   <= sq_arr_r[ch_r] + SQ_W'(sq_x_r)
                          - (full_ch ? SQ_W'(sq_old_r) : '0);
        seen_r[ch_r]     <= 1'b1;
      end
      if (st_we) begin
        stat_arr_r[ch_r] <= st_val;
      end
    end
  end

  assign in_ready            = (state_r == lad_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_severity        = out_sev_r;
  assign out_channel_status  = out_stat_r;
  assign out_alert           = (out_sev_r != lad_pkg::SEV_NORMAL);
  assign out_detect_method   = out_meth_r;
  assign out_alert_threshold = out_thr_r;
  assign out_alert_latency   = out_lat_r;

  a_quiet_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_alert) |-> (out_detect_method == lad_pkg::DET_NONE &&
      out_alert_threshold == '0 && out_alert_latency == '0))
    else $error("beat without alert carries alert fields");

  a_stat_sev: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_detect_method == lad_pkg::DET_STAT) |->
      (out_severity == lad_pkg::SEV_WARN || out_severity == lad_pkg::SEV_CRIT))
    else $error("statistical alert without severity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_ch <= CNT_W'(WINDOW)))
    else $error("window fill beyond window length");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && req_in == lad_pkg::REQ_CLR_ALL) |=> (seen_r == '0))
    else $error("clear all left a channel marked seen");

endmodule
